@@ sv/i2cms_pkg.sv @@
// i2cms_pkg: shared types, codes and sizes of the i2c message sequencer
// no dependencies; imported by the front, back and top level
package i2cms_pkg;

   // default sizes
   localparam int MAX_MSGS_DEF  = 8;
   localparam int MAX_BYTES_DEF = 32;
   localparam int MAX_RES       = 16;

   // input commands
   localparam logic [2:0] CMD_LDESC = 3'd0;
   localparam logic [2:0] CMD_LBYTE = 3'd1;
   localparam logic [2:0] CMD_START = 3'd2;
   localparam logic [2:0] CMD_ACK   = 3'd3;
   localparam logic [2:0] CMD_NACK  = 3'd4;
   localparam logic [2:0] CMD_ARB   = 3'd5;
   localparam logic [2:0] CMD_RXB   = 3'd6;

   // classified word kinds
   localparam logic [2:0] K_LDESC = 3'd0;
   localparam logic [2:0] K_LBYTE = 3'd1;
   localparam logic [2:0] K_START = 3'd2;
   localparam logic [2:0] K_ACK   = 3'd3;
   localparam logic [2:0] K_NACK  = 3'd4;
   localparam logic [2:0] K_ARB   = 3'd5;
   localparam logic [2:0] K_RXB   = 3'd6;
   localparam logic [2:0] K_BAD   = 3'd7;

   // controller actions
   localparam logic [3:0] A_START   = 4'd0;
   localparam logic [3:0] A_RSTART  = 4'd1;
   localparam logic [3:0] A_STOP    = 4'd2;
   localparam logic [3:0] A_TX      = 4'd3;
   localparam logic [3:0] A_RX      = 4'd4;
   localparam logic [3:0] A_SEND    = 4'd5;
   localparam logic [3:0] A_ACK     = 4'd6;
   localparam logic [3:0] A_NACK    = 4'd7;
   localparam logic [3:0] A_RXBYTE  = 4'd8;
   localparam logic [3:0] A_STATUS  = 4'd9;
   localparam logic [3:0] A_DONE    = 4'd10;
   localparam logic [3:0] A_IGNORED = 4'd11;

   // message status codes
   localparam logic [1:0] ST_NODEV = 2'd0;
   localparam logic [1:0] ST_NOACK = 2'd1;
   localparam logic [1:0] ST_ARB   = 2'd2;

   // one classified word in the queue
   typedef struct packed {
      logic [2:0] kind;
      logic [2:0] msg_index;
      logic [9:0] dev_addr;
      logic       is_write;
      logic       ten_bit;
      logic       err_skip;
      logic [5:0] msg_len;
      logic [4:0] byte_index;
      logic [7:0] data_byte;
      logic [3:0] msg_count;
   } item_type;

   // queue head towards the back part
   typedef struct packed {
      logic     valid;
      item_type item;
   } q_link_type;

endpackage

@@ sv/i2cms_front.sv @@
// i2cms_front: accepts request words, classifies the command, two-entry queue
// depends on i2cms_pkg
module i2cms_front import i2cms_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [2:0] req_command,
   input  logic [2:0] req_msg_index,
   input  logic [9:0] req_dev_addr,
   input  logic       req_is_write,
   input  logic       req_ten_bit,
   input  logic       req_err_skip,
   input  logic [5:0] req_msg_len,
   input  logic [4:0] req_byte_index,
   input  logic [7:0] req_data_byte,
   input  logic [3:0] req_msg_count,
   output q_link_type q_head,
   input  logic       q_pop
);

   item_type   slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       push;
   item_type   cls;

   // classify the command
   always_comb begin
      cls            = '0;
      cls.msg_index  = req_msg_index;
      cls.dev_addr   = req_dev_addr;
      cls.is_write   = req_is_write;
      cls.ten_bit    = req_ten_bit;
      cls.err_skip   = req_err_skip;
      cls.msg_len    = req_msg_len;
      cls.byte_index = req_byte_index;
      cls.data_byte  = req_data_byte;
      cls.msg_count  = req_msg_count;
      case (req_command)
         CMD_LDESC: cls.kind = K_LDESC;
         CMD_LBYTE: cls.kind = K_LBYTE;
         CMD_START: cls.kind = K_START;
         CMD_ACK:   cls.kind = K_ACK;
         CMD_NACK:  cls.kind = K_NACK;
         CMD_ARB:   cls.kind = K_ARB;
         CMD_RXB:   cls.kind = K_RXB;
         default:   cls.kind = K_BAD;
      endcase
   end

   assign req_stall = (count_ff == 2'd2);
   assign push      = req_valid && !req_stall;

   // queue pointers
   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ q_pop;
      count_in  = count_ff + {1'b0, push} - {1'b0, q_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // queue storage
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= cls;
      end
   end

   assign q_head.valid = (count_ff != 2'd0);
   assign q_head.item  = slot_ff[rd_ptr_ff];

endmodule

@@ sv/i2cms_back.sv @@
// i2cms_back: transfer sequencer, descriptor and write-byte stores, result register
// depends on i2cms_pkg; fed by i2cms_front
module i2cms_back import i2cms_pkg::*; #(
   parameter int MAX_MSGS  = MAX_MSGS_DEF,
   parameter int MAX_BYTES = MAX_BYTES_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  q_link_type q_head,
   output logic       q_pop,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [3:0] rsp_action,
   output logic [7:0] rsp_byte_value,
   output logic [2:0] rsp_out_msg,
   output logic [4:0] rsp_out_byte,
   output logic [1:0] rsp_status,
   output logic       rsp_last
);

   localparam int MW    = $clog2(MAX_MSGS + 1);
   localparam int IW    = (MAX_MSGS > 1) ? $clog2(MAX_MSGS) : 1;
   localparam int BW    = $clog2(MAX_BYTES + 1);
   localparam int DEPTH = MAX_MSGS * MAX_BYTES;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   // phases of the transfer
   localparam logic [2:0] PH_IDLE   = 3'd0;
   localparam logic [2:0] PH_ADDR7  = 3'd1;
   localparam logic [2:0] PH_ADDR1R = 3'd2;
   localparam logic [2:0] PH_ADDR1W = 3'd3;
   localparam logic [2:0] PH_SEND   = 3'd4;
   localparam logic [2:0] PH_RECV   = 3'd5;

   // sequencer steps
   localparam logic [4:0] S_POP   = 5'd0;
   localparam logic [4:0] S_IGN   = 5'd1;
   localparam logic [4:0] S_BEG   = 5'd2;
   localparam logic [4:0] S_DONE  = 5'd3;
   localparam logic [4:0] S_BTX   = 5'd4;
   localparam logic [4:0] S_BADR  = 5'd5;
   localparam logic [4:0] S_RX    = 5'd6;
   localparam logic [4:0] S_RXA   = 5'd7;
   localparam logic [4:0] S_A1LO  = 5'd8;
   localparam logic [4:0] S_A1RS  = 5'd9;
   localparam logic [4:0] S_A1TX  = 5'd10;
   localparam logic [4:0] S_A1HI  = 5'd11;
   localparam logic [4:0] S_SWAIT = 5'd12;
   localparam logic [4:0] S_SDAT  = 5'd13;
   localparam logic [4:0] S_RNA   = 5'd14;
   localparam logic [4:0] S_RSR   = 5'd15;
   localparam logic [4:0] S_RXB   = 5'd16;
   localparam logic [4:0] S_FAIL  = 5'd17;
   localparam logic [4:0] S_FCHK  = 5'd18;

   // descriptor table
   logic [9:0]    d_addr_ff [MAX_MSGS];
   logic          d_wr_ff   [MAX_MSGS];
   logic          d_ten_ff  [MAX_MSGS];
   logic          d_skip_ff [MAX_MSGS];
   logic [BW-1:0] d_len_ff  [MAX_MSGS];

   // write byte store
   logic [7:0]    wmem [DEPTH];
   logic [7:0]    rd_ff;
   logic [AW-1:0] raddr, waddr;
   logic          wmem_we, desc_we;
   logic [BW-1:0] len_sat;

   // control state
   logic [4:0]    st_ff, st_in;
   logic [2:0]    phase_ff, phase_in;
   logic [MW-1:0] cur_ff, cur_in;
   logic [MW-1:0] act_ff, act_in;
   logic [BW-1:0] bc_ff, bc_in;
   logic          first_ff, first_in;
   logic [1:0]    code_ff, code_in;
   logic [7:0]    dbyte_ff, dbyte_in;
   logic [4:0]    cnt_ff, cnt_in;

   // result register
   logic          rv_ff, rv_in;
   logic [3:0]    ra_ff, ra_in;
   logic [7:0]    rb_ff, rb_in;
   logic [2:0]    rm_ff, rm_in;
   logic [4:0]    rp_ff, rp_in;
   logic [1:0]    rs_ff, rs_in;
   logic          rl_ff, rl_in;

   // current descriptor
   logic [9:0]    c_addr;
   logic          c_wr, c_ten, c_skip;
   logic [BW-1:0] c_len;
   logic          cur_ok;
   logic [BW:0]   bc1, bc2, len_x;

   // emit step
   logic          is_emit, fire, do_out, e_fin;
   logic [3:0]    e_act;
   logic [7:0]    e_val;
   logic [2:0]    e_msg;
   logic [4:0]    e_pos;
   logic [1:0]    e_st;
   logic          out_free;
   logic [3:0]    mcnt;
   logic [MW-1:0] cnt_sat;
   item_type      it;

   assign it     = q_head.item;
   assign cur_ok = (int'(cur_ff) < MAX_MSGS);
   assign c_addr = d_addr_ff[cur_ff[IW-1:0]];
   assign c_wr   = d_wr_ff[cur_ff[IW-1:0]];
   assign c_ten  = d_ten_ff[cur_ff[IW-1:0]];
   assign c_skip = d_skip_ff[cur_ff[IW-1:0]];
   assign c_len  = d_len_ff[cur_ff[IW-1:0]];
   assign len_x  = {1'b0, c_len};
   assign bc1    = {1'b0, bc_ff} + (BW+1)'(1);
   assign bc2    = {1'b0, bc_ff} + (BW+1)'(2);
   assign mcnt   = it.msg_count;
   assign cnt_sat = (int'(mcnt) > MAX_MSGS) ? MW'(MAX_MSGS) : MW'(mcnt);
   assign len_sat = (int'(it.msg_len) > MAX_BYTES) ? BW'(MAX_BYTES) : BW'(it.msg_len);
   assign out_free = !rv_ff || !rsp_stall;

   // store write and read addresses
   assign waddr   = AW'(int'(it.msg_index) * MAX_BYTES + int'(it.byte_index));
   assign raddr   = AW'(int'(cur_ff) * MAX_BYTES + int'(bc_ff));
   assign q_pop   = (st_ff == S_POP) && q_head.valid;
   assign desc_we = q_pop && (it.kind == K_LDESC) && (int'(it.msg_index) < MAX_MSGS);
   assign wmem_we = q_pop && (it.kind == K_LBYTE) && (int'(it.msg_index) < MAX_MSGS)
                    && (int'(it.byte_index) < MAX_BYTES);

   always_ff @(posedge clock) begin
      if (desc_we) begin
         d_addr_ff[it.msg_index[IW-1:0]] <= it.dev_addr;
         d_wr_ff[it.msg_index[IW-1:0]]   <= it.is_write;
         d_ten_ff[it.msg_index[IW-1:0]]  <= it.ten_bit;
         d_skip_ff[it.msg_index[IW-1:0]] <= it.err_skip;
         d_len_ff[it.msg_index[IW-1:0]]  <= len_sat;
      end
   end

   always_ff @(posedge clock) begin
      if (wmem_we) begin
         wmem[waddr] <= it.data_byte;
      end
      rd_ff <= wmem[raddr];
   end

   // which action this step emits
   always_comb begin
      is_emit = 1'b1;
      e_act   = A_IGNORED;
      e_val   = 8'd0;
      e_msg   = cur_ff[2:0];
      e_pos   = 5'd0;
      e_st    = 2'd0;
      e_fin   = 1'b0;
      case (st_ff)
         S_IGN: begin
            e_msg = 3'd0;
            e_fin = 1'b1;
         end
         S_BEG: begin
            if (cur_ff >= act_ff) begin
               e_act = A_STOP;
               e_msg = 3'd0;
            end else begin
               e_act = first_ff ? A_START : A_RSTART;
            end
         end
         S_DONE: begin
            e_act = A_DONE;
            e_msg = 3'd0;
            e_fin = 1'b1;
         end
         S_BTX, S_A1TX: e_act = A_TX;
         S_BADR: begin
            e_act = A_SEND;
            e_fin = 1'b1;
            if (c_ten) begin
               e_val = 8'hf0 | {5'd0, c_addr[9:8], !c_wr};
            end else begin
               e_val = {c_addr[7:1], !c_wr};
            end
         end
         S_RX: e_act = A_RX;
         S_RXA: begin
            e_act = (c_len <= BW'(1)) ? A_NACK : A_ACK;
            e_fin = 1'b1;
         end
         S_A1LO: begin
            e_act = A_SEND;
            e_val = c_addr[7:0];
            e_fin = (phase_ff == PH_ADDR1W);
         end
         S_A1RS: e_act = A_RSTART;
         S_A1HI: begin
            e_act = A_SEND;
            e_val = 8'hf0 | {5'd0, c_addr[9:8], 1'b1};
            e_fin = 1'b1;
         end
         S_SDAT: begin
            e_act = A_SEND;
            e_val = rd_ff;
            e_fin = 1'b1;
         end
         S_RNA: e_act = (bc2 >= len_x) ? A_NACK : A_ACK;
         S_RSR: e_act = (cur_ff + MW'(1) == act_ff) ? A_STOP : A_RSTART;
         S_RXB: begin
            e_act = A_RXBYTE;
            e_val = dbyte_ff;
            e_pos = bc_ff[4:0];
            e_fin = (bc1 < len_x);
         end
         S_FAIL: begin
            e_act = A_STATUS;
            e_st  = code_ff;
         end
         default: is_emit = 1'b0;
      endcase
   end

   assign fire   = is_emit && (out_free || (int'(cnt_ff) >= MAX_RES));
   assign do_out = fire && (int'(cnt_ff) < MAX_RES);

   // sequencer
   always_comb begin
      st_in    = st_ff;
      phase_in = phase_ff;
      cur_in   = cur_ff;
      act_in   = act_ff;
      bc_in    = bc_ff;
      first_in = first_ff;
      code_in  = code_ff;
      dbyte_in = dbyte_ff;
      cnt_in   = cnt_ff;
      if (do_out) begin
         cnt_in = cnt_ff + 5'd1;
      end
      case (st_ff)
         S_POP: begin
            if (q_head.valid) begin
               cnt_in   = 5'd0;
               dbyte_in = it.data_byte;
               st_in    = S_IGN;
               case (it.kind)
                  K_LDESC, K_LBYTE: st_in = S_POP;
                  K_START: begin
                     if (phase_ff == PH_IDLE) begin
                        act_in   = cnt_sat;
                        cur_in   = '0;
                        bc_in    = '0;
                        first_in = 1'b1;
                        st_in    = S_BEG;
                     end
                  end
                  K_ACK: begin
                     case (phase_ff)
                        PH_ADDR7:             st_in = S_RX;
                        PH_ADDR1R, PH_ADDR1W: st_in = S_A1LO;
                        PH_SEND: begin
                           if (bc_ff >= c_len) begin
                              cur_in   = cur_ff + MW'(1);
                              first_in = 1'b0;
                              st_in    = S_BEG;
                           end else begin
                              st_in = S_SWAIT;
                           end
                        end
                        default: st_in = S_IGN;
                     endcase
                  end
                  K_NACK: begin
                     if (phase_ff inside {PH_ADDR7, PH_ADDR1R, PH_ADDR1W, PH_SEND}) begin
                        code_in = (phase_ff == PH_SEND && bc_ff != '0) ? ST_NOACK : ST_NODEV;
                        st_in   = S_FAIL;
                     end
                  end
                  K_ARB: begin
                     if (phase_ff != PH_IDLE) begin
                        code_in = ST_ARB;
                        st_in   = S_FAIL;
                     end
                  end
                  K_RXB: begin
                     if (phase_ff == PH_RECV) begin
                        st_in = S_RNA;
                     end
                  end
                  default: st_in = S_IGN;
               endcase
            end
         end
         S_IGN: if (fire) st_in = S_POP;
         S_BEG: begin
            if (fire) begin
               first_in = 1'b0;
               bc_in    = '0;
               st_in    = (cur_ff >= act_ff) ? S_DONE : S_BTX;
            end
         end
         S_DONE: begin
            if (fire) begin
               phase_in = PH_IDLE;
               cur_in   = '0;
               act_in   = '0;
               bc_in    = '0;
               st_in    = S_POP;
            end
         end
         S_BTX: if (fire) st_in = S_BADR;
         S_BADR: begin
            if (fire) begin
               if (c_ten) begin
                  phase_in = c_wr ? PH_ADDR1W : PH_ADDR1R;
               end else begin
                  phase_in = c_wr ? PH_SEND : PH_ADDR7;
               end
               st_in = S_POP;
            end
         end
         S_RX: if (fire) st_in = S_RXA;
         S_RXA: begin
            if (fire) begin
               phase_in = PH_RECV;
               st_in    = S_POP;
            end
         end
         S_A1LO: begin
            if (fire) begin
               if (phase_ff == PH_ADDR1W) begin
                  phase_in = PH_SEND;
                  st_in    = S_POP;
               end else begin
                  st_in = S_A1RS;
               end
            end
         end
         S_A1RS: if (fire) st_in = S_A1TX;
         S_A1TX: if (fire) st_in = S_A1HI;
         S_A1HI: begin
            if (fire) begin
               phase_in = PH_ADDR7;
               st_in    = S_POP;
            end
         end
         S_SWAIT: st_in = S_SDAT;
         S_SDAT: begin
            if (fire) begin
               bc_in = bc_ff + BW'(1);
               st_in = S_POP;
            end
         end
         S_RNA: begin
            if (fire) begin
               if (bc2 >= len_x && bc1 >= len_x) begin
                  st_in = S_RSR;
               end else begin
                  st_in = S_RXB;
               end
            end
         end
         S_RSR: if (fire) st_in = S_RXB;
         S_RXB: begin
            if (fire) begin
               bc_in = BW'(bc1);
               if (bc1 >= len_x) begin
                  cur_in   = cur_ff + MW'(1);
                  first_in = 1'b0;
                  st_in    = S_BEG;
               end else begin
                  st_in = S_POP;
               end
            end
         end
         S_FAIL: begin
            if (fire) begin
               cur_in = cur_ff + MW'(1);
               st_in  = S_FCHK;
            end
         end
         S_FCHK: begin
            first_in = 1'b0;
            if (cur_ff < act_ff && cur_ok && c_skip) begin
               st_in = S_FAIL;
            end else begin
               st_in = S_BEG;
            end
         end
         default: st_in = S_POP;
      endcase
   end

   // result register
   always_comb begin
      rv_in = rv_ff;
      ra_in = ra_ff;
      rb_in = rb_ff;
      rm_in = rm_ff;
      rp_in = rp_ff;
      rs_in = rs_ff;
      rl_in = rl_ff;
      if (do_out) begin
         rv_in = 1'b1;
         ra_in = e_act;
         rb_in = e_val;
         rm_in = e_msg;
         rp_in = e_pos;
         rs_in = e_st;
         rl_in = e_fin || (int'(cnt_ff) == MAX_RES - 1);
      end else if (!rsp_stall) begin
         rv_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff    <= S_POP;
         phase_ff <= PH_IDLE;
         cur_ff   <= '0;
         act_ff   <= '0;
         bc_ff    <= '0;
         first_ff <= 1'b0;
         code_ff  <= ST_NODEV;
         cnt_ff   <= 5'd0;
         rv_ff    <= 1'b0;
      end else begin
         st_ff    <= st_in;
         phase_ff <= phase_in;
         cur_ff   <= cur_in;
         act_ff   <= act_in;
         bc_ff    <= bc_in;
         first_ff <= first_in;
         code_ff  <= code_in;
         cnt_ff   <= cnt_in;
         rv_ff    <= rv_in;
      end
   end

   always_ff @(posedge clock) begin
      dbyte_ff <= dbyte_in;
      ra_ff    <= ra_in;
      rb_ff    <= rb_in;
      rm_ff    <= rm_in;
      rp_ff    <= rp_in;
      rs_ff    <= rs_in;
      rl_ff    <= rl_in;
   end

   assign rsp_valid      = rv_ff;
   assign rsp_action     = ra_ff;
   assign rsp_byte_value = rb_ff;
   assign rsp_out_msg    = rm_ff;
   assign rsp_out_byte   = rp_ff;
   assign rsp_status     = rs_ff;
   assign rsp_last       = rl_ff;

endmodule

@@ sv/i2c_master_message_sequencer.sv @@
// i2c_master_message_sequencer: top level of the i2c message sequencer
// depends on i2cms_pkg, i2cms_front and i2cms_back
//
//   channel   direction   handshake             payload
//   req_*     in          req_valid/req_stall   command and descriptor fields
//   rsp_*     out         rsp_valid/rsp_stall   one controller action per word
//
// a load word only leaves the queue; any other word leaves the queue and then emits
// the actions it causes; a send data byte adds a step for the store read and each
// message marked on error adds a step for the descriptor check
// reset is synchronous and clears the queue, the sequencer and the result valid flag
// a stall on rsp_* holds the sequencer at each action it emits; the queue keeps taking req_* words until full
module i2c_master_message_sequencer import i2cms_pkg::*; #(
   parameter int MAX_MSGS  = MAX_MSGS_DEF,
   parameter int MAX_BYTES = MAX_BYTES_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [2:0] req_command,
   input  logic [2:0] req_msg_index,
   input  logic [9:0] req_dev_addr,
   input  logic       req_is_write,
   input  logic       req_ten_bit,
   input  logic       req_err_skip,
   input  logic [5:0] req_msg_len,
   input  logic [4:0] req_byte_index,
   input  logic [7:0] req_data_byte,
   input  logic [3:0] req_msg_count,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [3:0] rsp_action,
   output logic [7:0] rsp_byte_value,
   output logic [2:0] rsp_out_msg,
   output logic [4:0] rsp_out_byte,
   output logic [1:0] rsp_status,
   output logic       rsp_last
);

   q_link_type q_head;
   logic       q_pop;

   // front: accept and classify
   i2cms_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_command    (req_command),
      .req_msg_index  (req_msg_index),
      .req_dev_addr   (req_dev_addr),
      .req_is_write   (req_is_write),
      .req_ten_bit    (req_ten_bit),
      .req_err_skip   (req_err_skip),
      .req_msg_len    (req_msg_len),
      .req_byte_index (req_byte_index),
      .req_data_byte  (req_data_byte),
      .req_msg_count  (req_msg_count),
      .q_head         (q_head),
      .q_pop          (q_pop)
   );

   // back: sequence the transfer
   i2cms_back #(
      .MAX_MSGS  (MAX_MSGS),
      .MAX_BYTES (MAX_BYTES)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .q_head         (q_head),
      .q_pop          (q_pop),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_action     (rsp_action),
      .rsp_byte_value (rsp_byte_value),
      .rsp_out_msg    (rsp_out_msg),
      .rsp_out_byte   (rsp_out_byte),
      .rsp_status     (rsp_status),
      .rsp_last       (rsp_last)
   );

endmodule
